// File: hdl/pip_pkg.sv
package pip_pkg;

  localparam int unsigned IDX_WIDTH = 10;
  localparam int unsigned CNT_WIDTH = 11;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_DRAIN = 3'b100
  } pip_state_e;

endpackage

// File: hdl/point_in_polygon_test.sv
// point-in-polygon test, even-odd crossing rule, over a polygon held in a vertex store.
// requests enter on start/busy: a request is taken at a rising edge with start high and
// busy low. func_i selects the kind of request:
//   load  - writes coord_x_i/coord_y_i to slot vertex_index_i, busy stays low, no
//           result; an index beyond the store is dropped
//   query - tests point (coord_x_i, coord_y_i) against the first vertex_count_i vertices
//           (clamped to MAX_VERTICES); busy is high until the result shows
// the result is on inside_res_o for exactly one cycle, marked by res_valid_o; the
// receiver cannot hold it off, and a new request may be taken in that same cycle.
// a query with count n > 0 reads n + 1 vertices from the single read port of the store,
// one per cycle, and walks one edge per cycle through a shared difference, multiply and
// compare pipeline (read data, difference, product and result registers in that order);
// a query with count 0 answers outside in the cycle after the request.
// throughput is set by the store read port: one edge per cycle; a new query or load is
// taken only once busy is low again, and a load leaves busy low.
// reset clears the sequencer, the pipeline valid flags and the result; store entries are undefined
// until written and must be loaded before a query reads them.
module point_in_polygon_test #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic [pip_pkg::IDX_WIDTH-1:0]       vertex_index_i,
  input  logic signed [COORD_WIDTH-1:0]       coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]       coord_y_i,
  input  logic [pip_pkg::CNT_WIDTH-1:0]       vertex_count_i,
  output logic                                res_valid_o,
  output logic                                inside_res_o
);
  import pip_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned MW = 2 * COORD_WIDTH;

  pip_state_e state_q, state_d;

  logic                          accept;
  logic                          load_req;
  logic                          query_req;
  logic                          zero_query;
  logic [NW-1:0]                 n_clamped;

  logic signed [COORD_WIDTH-1:0] px_q, py_q;
  logic [NW-1:0]                 n_q;
  logic [NW-1:0]                 k_q, k_d;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;

  logic [MW-1:0]                 mem [MAX_VERTICES];
  logic [MW-1:0]                 rdata_q;
  logic                          v1_q, f1_q, l1_q;

  logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic                          spans_d, dypos_d;

  logic                          v2_q, l2_q, spans2_q, dypos2_q;
  logic signed [DW-1:0]          a_q, dy_q, b_q, c_q;

  logic                          v3_q, l3_q, spans3_q, dypos3_q;
  logic signed [PW-1:0]          p1_q, p2_q;

  logic                          tog;
  logic                          inside_q;
  logic                          done_q;
  logic                          res_q;

  assign accept     = start && !busy;
  assign load_req   = accept && (func_i == FUNC_LOAD);
  assign query_req  = accept && (func_i == FUNC_QUERY);
  assign zero_query = query_req && (vertex_count_i == '0);

  always_comb begin
    if (32'(vertex_count_i) > 32'(MAX_VERTICES)) begin
      n_clamped = NW'(MAX_VERTICES);
    end else begin
      n_clamped = NW'(vertex_count_i);
    end
  end

  // sequencer: read vertex n-1 first, then 0 .. n-1
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    rd_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (query_req && !zero_query) begin
          state_d = ST_READ;
          k_d     = '0;
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        k_d   = k_q + NW'(1);
        if (k_q == n_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v3_q && l3_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = (k_q == '0) ? AW'(n_q - NW'(1)) : AW'(k_q - NW'(1));
  assign busy    = (state_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (load_req && (32'(vertex_index_i) < 32'(MAX_VERTICES))) begin
      mem[AW'(vertex_index_i)] <= {coord_x_i, coord_y_i};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign cur_x = rdata_q[MW-1:COORD_WIDTH];
  assign cur_y = rdata_q[COORD_WIDTH-1:0];

  // half-open y span; dypos means the previous vertex lies above the current one
  assign spans_d = ((cur_y <= py_q) && (py_q < prev_y_q)) ||
                   ((prev_y_q <= py_q) && (py_q < cur_y));
  assign dypos_d = (prev_y_q > cur_y);

  always_ff @(posedge clk_i) begin
    if (query_req) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
      n_q  <= n_clamped;
    end
    if (v1_q) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
    if (v1_q && !f1_q) begin
      a_q      <= {px_q[COORD_WIDTH-1], px_q} - {cur_x[COORD_WIDTH-1], cur_x};
      dy_q     <= {prev_y_q[COORD_WIDTH-1], prev_y_q} - {cur_y[COORD_WIDTH-1], cur_y};
      b_q      <= {prev_x_q[COORD_WIDTH-1], prev_x_q} - {cur_x[COORD_WIDTH-1], cur_x};
      c_q      <= {py_q[COORD_WIDTH-1], py_q} - {cur_y[COORD_WIDTH-1], cur_y};
      spans2_q <= spans_d;
      dypos2_q <= dypos_d;
    end
    if (v2_q) begin
      p1_q     <= a_q * dy_q;
      p2_q     <= b_q * c_q;
      spans3_q <= spans2_q;
      dypos3_q <= dypos2_q;
    end
  end

  // crossing right of the point, compare direction follows the sign of dy
  assign tog = spans3_q && (dypos3_q ? (p1_q < p2_q) : (p1_q > p2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      k_q      <= '0;
      v1_q     <= 1'b0;
      f1_q     <= 1'b0;
      l1_q     <= 1'b0;
      v2_q     <= 1'b0;
      l2_q     <= 1'b0;
      v3_q     <= 1'b0;
      l3_q     <= 1'b0;
      inside_q <= 1'b0;
      done_q   <= 1'b0;
      res_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      v1_q    <= rd_en;
      f1_q    <= rd_en && (k_q == '0);
      l1_q    <= rd_en && (k_q == n_q);
      v2_q    <= v1_q && !f1_q;
      l2_q    <= v1_q && !f1_q && l1_q;
      v3_q    <= v2_q;
      l3_q    <= v2_q && l2_q;
      if (query_req) begin
        inside_q <= 1'b0;
      end else if (v3_q && tog) begin
        inside_q <= ~inside_q;
      end
      done_q <= zero_query || (v3_q && l3_q);
      if (zero_query) begin
        res_q <= 1'b0;
      end else if (v3_q && l3_q) begin
        res_q <= inside_q ^ tog;
      end
    end
  end

  assign res_valid_o  = done_q;
  assign inside_res_o = res_q;

endmodule

// File: hdl/pip_checker.sv
module pip_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          func_i,
  input logic [pip_pkg::CNT_WIDTH-1:0] vertex_count_i,
  input logic                          res_valid_o
);
  import pip_pkg::*;

  logic query_req;
  logic load_req;

  assign query_req = start && !busy && (func_i == FUNC_QUERY);
  assign load_req  = start && !busy && (func_i == FUNC_LOAD);

  // busy only comes from a query request
  a_busy_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(query_req))
    else $error("busy rose without a query request");

  // the walk ends exactly when the result shows
  a_fall_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("busy fell without a result");

  // a result always follows a running walk or a zero-count query
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(busy) || $past(query_req && (vertex_count_i == '0))))
    else $error("result strobe without a query");

  // a load never produces a result and never makes the block busy
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_req |=> (!res_valid_o && !busy))
    else $error("load request produced a result or busy");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .func_i         (func_i),
  .vertex_count_i (vertex_count_i),
  .res_valid_o    (res_valid_o)
);
